// ===== sv/isra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isra_pkg
// Shared types and constants for the interval slot reuse allocator.
// ----------------------------------------------------------------------------
package isra_pkg;

    localparam int MAX_SLOTS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 16;

    localparam int USE_W       = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int ADDR_W      = 24;
    localparam int COUNT_W     = 5;
    localparam int BYTES_W     = 21;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = BYTES_W;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 5'd4;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = 21'h20000;
    localparam logic [ADDR_W-1:0]  ADDR_MAX         = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

    typedef struct packed {
        logic [USE_W-1:0] first_use;
        logic [USE_W-1:0] last_use;
        logic             restart;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     address;
        logic                  out_of_slots;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_PICK,
        ST_MULT,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic release_slots;
        logic pick;
        logic mult;
        logic load_out;
    } cmd_t;

endpackage

// ===== sv/isra_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isra_ctrl
// Sequencer for one interval: release, pick, address multiply, hand-off.
// ----------------------------------------------------------------------------
module isra_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output isra_pkg::cmd_t   cmd
);

    isra_pkg::state_t state_reg;
    isra_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            isra_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = isra_pkg::ST_RELEASE;
                end
            end
            isra_pkg::ST_RELEASE:
            begin
                cmd.release_slots = 1'b1;
                state_next        = isra_pkg::ST_PICK;
            end
            isra_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = isra_pkg::ST_MULT;
            end
            isra_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = isra_pkg::ST_DONE;
            end
            isra_pkg::ST_DONE:
            begin
                // wait for the output register to be free or being taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = isra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isra_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an untaken transaction");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == isra_pkg::ST_RELEASE))
        else $error("accepted interval did not start release");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== sv/isra_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isra_dp
// Slot table, per-slot release compare, lowest-free pick and address multiply.
// ----------------------------------------------------------------------------
module isra_dp
#(
    parameter int MAX_SLOTS  = isra_pkg::MAX_SLOTS_DEF,
    parameter int INDEX_BITS = isra_pkg::INDEX_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  isra_pkg::cmd_t                      cmd,
    input  isra_pkg::in_item_t                  in_data,
    output isra_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [isra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isra_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PROD_W = SLOT_W + isra_pkg::BYTES_W;

    logic [isra_pkg::COUNT_W-1:0] slot_count_reg;
    logic [isra_pkg::BYTES_W-1:0] slot_bytes_reg;

    logic [INDEX_BITS-1:0] first_reg;
    logic [INDEX_BITS-1:0] last_reg;
    logic                  restart_reg;

    logic [MAX_SLOTS-1:0]  busy_reg;
    logic [MAX_SLOTS-1:0]  busy_next;
    logic [INDEX_BITS-1:0] last_use_mem [MAX_SLOTS];

    logic [SLOT_W-1:0]     pick_reg;
    logic                  found_reg;
    logic [SLOT_W-1:0]     pick_c;
    logic                  found_c;
    logic [MAX_SLOTS-1:0]  usable;

    logic [PROD_W-1:0]     prod;
    logic [31:0]           prod_wide;
    logic [31:0]           pick_wide;
    logic [31:0]           first_wide;
    logic [31:0]           last_wide;
    isra_pkg::out_item_t   result_reg;
    isra_pkg::out_item_t   out_reg;

    // index mask: keep the low INDEX_BITS of each use index
    assign first_wide = {16'd0, in_data.first_use};
    assign last_wide  = {16'd0, in_data.last_use};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= isra_pkg::SLOT_COUNT_RESET;
            slot_bytes_reg <= isra_pkg::SLOT_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                isra_pkg::CFG_SLOT_COUNT:
                    slot_count_reg <= cfg_data[isra_pkg::COUNT_W-1:0];
                isra_pkg::CFG_SLOT_BYTES:
                    slot_bytes_reg <= cfg_data;
                default:
                    slot_bytes_reg <= slot_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            first_reg   <= first_wide[INDEX_BITS-1:0];
            last_reg    <= last_wide[INDEX_BITS-1:0];
            restart_reg <= in_data.restart;
        end
    end

    // slot usable when below the configured count, which saturates at the bank size
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            usable[i] = ({27'd0, slot_count_reg} > 32'(i));
        end
    end

    // lowest free usable slot
    always_comb
    begin
        pick_c  = '0;
        found_c = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (usable[i] && !busy_reg[i])
            begin
                pick_c  = SLOT_W'(i);
                found_c = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.release_slots)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                if (restart_reg || (busy_reg[i] && (last_use_mem[i] < first_reg)))
                begin
                    busy_next[i] = 1'b0;
                end
            end
        end
        else if (cmd.pick && found_c)
        begin
            busy_next[pick_c] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            pick_reg  <= pick_c;
            found_reg <= found_c;
            if (found_c)
            begin
                last_use_mem[pick_c] <= last_reg;
            end
        end
    end

    assign prod      = PROD_W'(pick_reg) * PROD_W'(slot_bytes_reg);
    assign prod_wide = 32'(prod);
    assign pick_wide = 32'(pick_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            if (found_reg)
            begin
                result_reg.slot         <= pick_wide[isra_pkg::SLOT_OUT_W-1:0];
                result_reg.address      <= (prod_wide > 32'(isra_pkg::ADDR_MAX))
                                           ? isra_pkg::ADDR_MAX
                                           : prod_wide[isra_pkg::ADDR_W-1:0];
                result_reg.out_of_slots <= 1'b0;
            end
            else
            begin
                result_reg.slot         <= '0;
                result_reg.address      <= '0;
                result_reg.out_of_slots <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= result_reg;
        end
    end

    assign out_data = out_reg;

    a_pick_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && found_c) |=> busy_reg[pick_reg])
        else $error("granted slot not marked busy");

    a_pick_usable: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && found_c) |-> (usable[pick_c] && !busy_reg[pick_c]))
        else $error("granted slot not free and usable");

    a_release_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.release_slots |=> ((busy_reg & ~$past(busy_reg)) == '0))
        else $error("release set a busy bit");

    a_restart_frees_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.release_slots && restart_reg) |=> (busy_reg == '0))
        else $error("restart left a slot busy");

endmodule

// ===== sv/interval_slot_reuse_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_slot_reuse_allocator_top
// Linear-scan slot allocator: one live interval in, one slot grant out.
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid / in_stall / in_data: one interval per transaction
//   (first_use, last_use, restart), sorted by first use then last use
//   output channel out_valid / out_stall / out_data: one grant per interval
//   (slot, address = slot * slot_bytes saturated to 24 bits, out_of_slots)
//   config channel cfg_valid / cfg_ready / cfg_index / cfg_data: index 0 is
//   slot_count, index 1 is slot_bytes; write only while the block is idle
// timing
//   the sequencer walks release, pick, multiply and hand-off states after
//   an interval is taken and takes no new interval until it is back in idle,
//   so it works on one interval at a time
//   the output register lets the next interval be taken while a grant waits
// reset
//   all slots free, slot_count 4, slot_bytes 0x20000, no result pending
// stall
//   a stalled result holds; the next result then waits in the hand-off state
// ----------------------------------------------------------------------------
module interval_slot_reuse_allocator_top
#(
    parameter int MAX_SLOTS  = isra_pkg::MAX_SLOTS_DEF,
    parameter int INDEX_BITS = isra_pkg::INDEX_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  isra_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output isra_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [isra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [isra_pkg::CFG_DATA_W-1:0] cfg_data
);

    isra_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    isra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    isra_dp
    #(
        .MAX_SLOTS  (MAX_SLOTS),
        .INDEX_BITS (INDEX_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
